@@ rtl/core/ema_deadband_axis_filter_core_macros.svh @@
// ----------------------------------------------------------------------------
// EMA deadband filter assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EMA_DEADBAND_AXIS_FILTER_CORE_MACROS_SVH
`define EMA_DEADBAND_AXIS_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
`define EMADB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EMADB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EMADB_ASSERT(lbl, clk, rst_n, prop, msg)
`define EMADB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/emadb_pkg.sv @@
// ----------------------------------------------------------------------------
// EMA deadband filter package
// Word types, field widths, register codes and reset constants.
// ----------------------------------------------------------------------------
package emadb_pkg;

    localparam int DefChannels   = 6;
    localparam int DefSampleBits = 12;

    localparam int ChanW    = 3;
    localparam int SampleW  = 12;
    localparam int AlphaW   = 8;
    localparam int DbW      = 12;
    localparam int LimW     = 8;
    localparam int AxisW    = 8;
    localparam int RepW     = 9;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 12;

    localparam int EmaShift = 7;
    localparam int RepShift = 4;

    localparam logic [AlphaW-1:0] EmaScale      = 8'd128;
    localparam logic [AlphaW-1:0] AlphaReset    = 8'd32;
    localparam logic [DbW-1:0]    DeadbandReset = 12'd32;
    localparam logic [LimW-1:0]   LowLimReset   = 8'd5;
    localparam logic [LimW-1:0]   HighLimReset  = 8'd250;
    localparam logic [RepW-1:0]   RepReset      = 9'd300;
    localparam logic [AxisW-1:0]  RepMax        = 8'd255;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_DEADBAND  = 2'd1,
        CFG_LOW_LIMIT = 2'd2,
        CFG_HIGH_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ChanW-1:0]   channel;
        logic [SampleW-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [ChanW-1:0] channel_out;
        logic [AxisW-1:0] axis_value;
        logic             low_end;
        logic             high_end;
    } t_out;

endpackage

@@ rtl/core/ema_deadband_axis_filter_core.sv @@
// Path: a reported word is registered at the state read and at stage two, then in
// the output register. Throughput: one word per cycle while input ready is high;
// a three-step pipeline (state read, average update, deadband compare and write-back) around one state memory.
// Input ready drops only while the output word waits and stage two reports.
// Reset (synchronous, active low): registers to defaults, every channel reads
// average 0 / reported 300 through per-channel valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// EMA deadband axis filter core
// Per-channel exponential moving average with deadband-gated reporting and
// end-stop flags. Channel state lives in one memory with forwarding.
// ----------------------------------------------------------------------------
`include "ema_deadband_axis_filter_core_macros.svh"

module ema_deadband_axis_filter_core #(
    parameter int CHANNELS    = emadb_pkg::DefChannels,
    parameter int SAMPLE_BITS = emadb_pkg::DefSampleBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [emadb_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [emadb_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  emadb_pkg::t_in                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output emadb_pkg::t_out                 o_out_data
);
    import emadb_pkg::*;

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = (SAMPLE_BITS > SampleW) ? SAMPLE_BITS : SampleW;
    localparam int DW = SW + 2;
    localparam int EW = RepW + SAMPLE_BITS;
    localparam int PW = SAMPLE_BITS + AlphaW + 2;

    // configuration
    logic [AlphaW-1:0] r_alpha;
    logic [DbW-1:0]    r_deadband;
    logic [LimW-1:0]   r_low_lim;
    logic [LimW-1:0]   r_high_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= AlphaReset;
            r_deadband <= DeadbandReset;
            r_low_lim  <= LowLimReset;
            r_high_lim <= HighLimReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA:      r_alpha    <= i_cfg_data[AlphaW-1:0];
                CFG_DEADBAND:   r_deadband <= i_cfg_data[DbW-1:0];
                CFG_LOW_LIMIT:  r_low_lim  <= i_cfg_data[LimW-1:0];
                CFG_HIGH_LIMIT: r_high_lim <= i_cfg_data[LimW-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline state
    logic                   adv;
    logic                   in_fire;
    logic                   in_ok;
    logic [IW-1:0]          in_idx;
    logic [SW-1:0]          in_smp_x;
    logic [SAMPLE_BITS-1:0] in_smp;

    logic [EW-1:0]          mem [CHANNELS];
    logic [CHANNELS-1:0]    r_vld;
    logic [EW-1:0]          r_rd;
    logic                   r_rd_vld;

    logic                   r_s1_vld;
    logic [ChanW-1:0]       r_s1_ch;
    logic [SAMPLE_BITS-1:0] r_s1_smp;

    logic                   r_s2_vld;
    logic [ChanW-1:0]       r_s2_ch;
    logic [SAMPLE_BITS-1:0] r_s2_avg;
    logic [RepW-1:0]        r_s2_rep;

    logic                   r_w_vld;
    logic [ChanW-1:0]       r_w_ch;
    logic [SAMPLE_BITS-1:0] r_w_avg;
    logic [RepW-1:0]        r_w_rep;

    logic                   r_out_vld;
    t_out                   r_out;

    logic                   wr_en;
    logic [IW-1:0]          w_idx;
    logic [EW-1:0]          wr_data;

    assign in_fire  = i_in_valid && o_in_ready;
    assign in_ok    = int'(i_in_data.channel) < CHANNELS;
    assign in_idx   = IW'(i_in_data.channel);
    assign in_smp_x = SW'(i_in_data.sample);
    assign in_smp   = in_smp_x[SAMPLE_BITS-1:0];

    // state memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[w_idx] <= wr_data;
        end
        if (in_fire && in_ok) begin
            r_rd     <= mem[in_idx];
            r_rd_vld <= r_vld[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[w_idx] <= 1'b1;
        end
    end

    // stage 1: forward and update average
    logic                   s1_hit2;
    logic                   s1_hitw;
    logic [SAMPLE_BITS-1:0] s1_mem_avg;
    logic [RepW-1:0]        s1_mem_rep;
    logic [SAMPLE_BITS-1:0] s1_old_avg;
    logic [RepW-1:0]        s1_old_rep;
    logic [AlphaW-1:0]      s1_alpha;
    logic signed [SAMPLE_BITS:0] s1_delta;
    logic signed [AlphaW:0] s1_alpha_s;
    logic signed [PW-1:0]   s1_prod;
    logic signed [PW-1:0]   s1_step;
    logic [SAMPLE_BITS-1:0] s1_new_avg;

    always_comb begin
        s1_mem_avg = r_rd_vld ? r_rd[SAMPLE_BITS-1:0] : '0;
        s1_mem_rep = r_rd_vld ? r_rd[EW-1:SAMPLE_BITS] : RepReset;
        s1_hit2    = r_s2_vld && (r_s2_ch == r_s1_ch);
        s1_hitw    = r_w_vld && (r_w_ch == r_s1_ch);
        s1_old_avg = s1_hit2 ? r_s2_avg : (s1_hitw ? r_w_avg : s1_mem_avg);
        s1_old_rep = s1_hitw ? r_w_rep : s1_mem_rep;
        s1_alpha   = (r_alpha > EmaScale) ? EmaScale : r_alpha;
        s1_delta   = signed'({1'b0, r_s1_smp}) - signed'({1'b0, s1_old_avg});
        s1_alpha_s = signed'({1'b0, s1_alpha});
        s1_prod    = s1_delta * s1_alpha_s;
        s1_step    = s1_prod >>> EmaShift;
        s1_new_avg = s1_old_avg + s1_step[SAMPLE_BITS-1:0];
    end

    // stage 2: deadband compare and report
    logic                   s2_hitw;
    logic [RepW-1:0]        s2_cur_rep;
    logic [DW-1:0]          s2_avg_d;
    logic [DW-1:0]          s2_cur_d;
    logic [DW-1:0]          s2_diff;
    logic                   s2_emit;
    logic [SW-1:0]          s2_avg_x;
    logic [SW-5:0]          s2_val_full;
    logic [AxisW-1:0]       s2_val;
    logic [RepW-1:0]        s2_new_rep;
    logic                   s2_lo;
    logic                   s2_hi;

    always_comb begin
        s2_hitw     = r_w_vld && (r_w_ch == r_s2_ch);
        s2_cur_rep  = s2_hitw ? r_w_rep : r_s2_rep;
        s2_avg_d    = DW'(r_s2_avg);
        s2_cur_d    = DW'(s2_cur_rep) << RepShift;
        s2_diff     = (s2_avg_d >= s2_cur_d) ? (s2_avg_d - s2_cur_d) : (s2_cur_d - s2_avg_d);
        s2_emit     = r_s2_vld && (s2_diff >= DW'(r_deadband));
        s2_avg_x    = SW'(r_s2_avg);
        s2_val_full = s2_avg_x[SW-1:RepShift];
        s2_val      = (s2_val_full > (SW-4)'(RepMax)) ? RepMax : s2_val_full[AxisW-1:0];
        s2_new_rep  = s2_emit ? RepW'(s2_val) : s2_cur_rep;
        s2_lo       = s2_val <= r_low_lim;
        s2_hi       = !s2_lo && (s2_val >= r_high_lim);
    end

    assign adv        = !(s2_emit && r_out_vld && !i_out_ready);
    assign o_in_ready = adv;
    assign wr_en      = adv && r_s2_vld;
    assign w_idx      = IW'(r_s2_ch);
    assign wr_data    = {s2_new_rep, r_s2_avg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_w_vld  <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= in_fire && in_ok;
            r_s2_vld <= r_s1_vld;
            r_w_vld  <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ch  <= i_in_data.channel;
            r_s1_smp <= in_smp;
            r_s2_ch  <= r_s1_ch;
            r_s2_avg <= s1_new_avg;
            r_s2_rep <= s1_old_rep;
            r_w_ch   <= r_s2_ch;
            r_w_avg  <= r_s2_avg;
            r_w_rep  <= s2_new_rep;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && s2_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s2_emit) begin
            r_out.channel_out <= r_s2_ch;
            r_out.axis_value  <= s2_val;
            r_out.low_end     <= s2_lo;
            r_out.high_end    <= s2_hi;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `EMADB_ASSERT(a_bad_ch_dropped, i_clk, i_rst_n, (in_fire && !in_ok) |=> !r_s1_vld, "out-of-range channel entered pipeline")
    `EMADB_ASSERT(a_wr_sets_vld, i_clk, i_rst_n, wr_en |=> r_vld[$past(w_idx)], "state write did not mark entry valid")
    `EMADB_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> (o_out_valid && !i_out_ready), "input stalled without output backpressure")
    `EMADB_ASSERT(a_flags_excl, i_clk, i_rst_n, o_out_valid |-> !(o_out_data.low_end && o_out_data.high_end), "both end flags set")

endmodule
